// ===== rtl/srt_pkg.sv =====
// Shared types and constants for the sorted record table.
// Record layout, operation and status codes, and controller/datapath command types.
// No dependencies.
package srt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int NAME_BYTES  = 30;
  localparam int NAME_SPAN   = 30;
  localparam int NAME_W      = NAME_SPAN * 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [15:0] year;
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w2;
    logic [47:0] w3;
  } rec_t;

  typedef struct packed {
    logic ld_new;
    logic ld_prev;
    logic ld_next;
  } cell_cmd_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/srt_cell.sv =====
// One entry of the sorted table: record storage, neighbor shift and key compare.
// Depends on srt_pkg.
module srt_cell (
  input  logic              clk,
  input  srt_pkg::cell_cmd_t cmd,
  input  srt_pkg::rec_t     new_rec,
  input  srt_pkg::rec_t     prev_rec,
  input  srt_pkg::rec_t     next_rec,
  output srt_pkg::rec_t     rec,
  output logic              key_lt
);
  import srt_pkg::*;

  rec_t rec_r;

  always_ff @(posedge clk) begin
    priority if (cmd.ld_prev) begin
      rec_r <= prev_rec;
    end else if (cmd.ld_new) begin
      rec_r <= new_rec;
    end else if (cmd.ld_next) begin
      rec_r <= next_rec;
    end else begin
      rec_r <= rec_r;
    end
  end

  assign rec    = rec_r;
  assign key_lt = (new_rec < rec_r);

endmodule

// ===== rtl/srt_ctrl.sv =====
// Request sequencer for the sorted record table: capture, evaluate, commit.
// Depends on srt_pkg.
module srt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  srt_pkg::dp_sts_t sts,
  output srt_pkg::dp_cmd_t cmd
);
  import srt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EVAL   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = S_EVAL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/srt_dp.sv =====
// Datapath for the sorted record table: request register, cell array, result register.
// Depends on srt_pkg and srt_cell.
module srt_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  srt_pkg::dp_cmd_t  cmd,
  output srt_pkg::dp_sts_t  sts,
  input  logic [1:0]        in_opcode,
  input  logic [15:0]       in_key_year,
  input  logic [6:0]        in_rank,
  input  logic [63:0]       in_name_w0,
  input  logic [63:0]       in_name_w1,
  input  logic [63:0]       in_name_w2,
  input  logic [47:0]       in_name_w3,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [15:0]       out_year,
  output logic [63:0]       out_name_w0,
  output logic [63:0]       out_name_w1,
  output logic [63:0]       out_name_w2,
  output logic [47:0]       out_name_w3,
  output logic [6:0]        out_entry_count
);
  import srt_pkg::*;

  logic [1:0]       op_r;
  logic [6:0]       rank_r;
  rec_t             key_r;
  logic [CNT_W-1:0] count_r;
  logic [TABLE_DEPTH-1:0] gt_r;
  logic [1:0]       status_r;
  rec_t             res_r;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  rec_t             out_rec_r;
  logic [CNT_W-1:0] out_count_r;

  rec_t       clean_rec;
  logic [NAME_W-1:0] name_raw, name_cln;
  logic       ended;

  rec_t       cell_rec [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_lt;
  cell_cmd_t  cell_cmd [TABLE_DEPTH];

  logic [IDX_W-1:0] idx;
  logic [1:0]       status_nxt;
  rec_t             rd_rec;
  logic [CNT_W-1:0] count_nxt;

  // Zero the name from its first zero byte on.
  always_comb begin
    name_raw = {in_name_w0, in_name_w1, in_name_w2, in_name_w3};
    name_cln = name_raw;
    ended    = 1'b0;
    for (int b = 0; b < NAME_SPAN; b++) begin
      if (name_raw[NAME_W-1-8*b -: 8] == 8'd0 || b >= NAME_BYTES) begin
        ended = 1'b1;
      end
      if (ended) begin
        name_cln[NAME_W-1-8*b -: 8] = 8'd0;
      end
    end
    clean_rec.year = in_key_year;
    {clean_rec.w0, clean_rec.w1, clean_rec.w2, clean_rec.w3} = name_cln;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_opcode;
      rank_r <= in_rank;
      key_r  <= clean_rec;
    end
  end

  assign idx = rank_r[IDX_W-1:0] - IDX_W'(1);

  always_comb begin
    unique case (op_r)
      OP_INSERT: status_nxt = (count_r == CNT_W'(TABLE_DEPTH)) ? ST_FULL : ST_OK;
      OP_DELETE,
      OP_READ:   status_nxt = (rank_r == 7'd0 || CNT_W'(rank_r) > count_r) ? ST_RANGE : ST_OK;
      default:   status_nxt = ST_RANGE;
    endcase
  end

  always_comb begin
    rd_rec = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (idx == IDX_W'(i)) begin
        rd_rec = rd_rec | cell_rec[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      status_r <= status_nxt;
      res_r    <= (op_r == OP_READ && status_nxt == ST_OK) ? rd_rec : '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        gt_r[i] <= cell_lt[i] && (CNT_W'(i) < count_r);
      end
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rec_t prev_rec, next_rec;
    if (i == 0) begin : g_first
      assign prev_rec = key_r;
    end else begin : g_mid
      assign prev_rec = cell_rec[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign next_rec = cell_rec[i];
    end else begin : g_inner
      assign next_rec = cell_rec[i+1];
    end

    always_comb begin
      cell_cmd[i] = '0;
      if (cmd.commit && status_r == ST_OK) begin
        if (op_r == OP_INSERT) begin
          cell_cmd[i].ld_prev = (i > 0) ? gt_r[(i > 0) ? i - 1 : 0] : 1'b0;
          cell_cmd[i].ld_new  = gt_r[i] || (count_r == CNT_W'(i));
        end else if (op_r == OP_DELETE) begin
          cell_cmd[i].ld_next = (IDX_W'(i) >= idx);
        end
      end
    end

    srt_cell u_cell (
      .clk      (clk),
      .cmd      (cell_cmd[i]),
      .new_rec  (key_r),
      .prev_rec (prev_rec),
      .next_rec (next_rec),
      .rec      (cell_rec[i]),
      .key_lt   (cell_lt[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (status_r == ST_OK) begin
      if (op_r == OP_INSERT) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (op_r == OP_DELETE) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= status_r;
      out_rec_r    <= res_r;
      out_count_r  <= count_nxt;
    end
  end

  assign sts.out_free     = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_year         = out_rec_r.year;
  assign out_name_w0      = out_rec_r.w0;
  assign out_name_w1      = out_rec_r.w1;
  assign out_name_w2      = out_rec_r.w2;
  assign out_name_w3      = out_rec_r.w3;
  assign out_entry_count  = 7'(out_count_r);

endmodule

// ===== rtl/sorted_record_table.sv =====
// Sorted record table: holds up to 64 records (16-bit year, 30-byte name) in
// ascending order of year, then name, in a row of cells that all compare the
// incoming key at once. Requests are insert, delete at 1-based rank and read at
// rank; each gives one result with status, read data and the new record count.
// A request is captured, evaluated against every cell in the next cycle and then
// committed (cells shift, result registered) once the result register is free;
// a new request is taken in the commit cycle. The result register holds a
// finished result while the next request is evaluated; while a result waits
// unaccepted, the commit and the input stall. No clearing pass after reset.
// Depends on srt_pkg, srt_ctrl, srt_dp.
module sorted_record_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_key_year,
  input  logic [6:0]  in_rank,
  input  logic [63:0] in_name_w0,
  input  logic [63:0] in_name_w1,
  input  logic [63:0] in_name_w2,
  input  logic [47:0] in_name_w3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_year,
  output logic [63:0] out_name_w0,
  output logic [63:0] out_name_w1,
  output logic [63:0] out_name_w2,
  output logic [47:0] out_name_w3,
  output logic [6:0]  out_entry_count
);
  import srt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  srt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_key_year     (in_key_year),
    .in_rank         (in_rank),
    .in_name_w0      (in_name_w0),
    .in_name_w1      (in_name_w1),
    .in_name_w2      (in_name_w2),
    .in_name_w3      (in_name_w3),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_year        (out_year),
    .out_name_w0     (out_name_w0),
    .out_name_w1     (out_name_w1),
    .out_name_w2     (out_name_w2),
    .out_name_w3     (out_name_w3),
    .out_entry_count (out_entry_count)
  );

endmodule

// ===== bench/sorted_record_table_tb.sv =====
// Testbench for sorted_record_table: drives insert, delete, read and unused-opcode
// requests and checks every result against a shadow copy of the sorted table.
// Depends on srt_pkg and the sorted_record_table RTL.
module sorted_record_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] year;
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w2;
    logic [47:0] w3;
    logic [6:0]  count;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = OP_INSERT;
  logic [15:0] in_key_year = '0;
  logic [6:0]  in_rank = '0;
  logic [63:0] in_name_w0 = '0;
  logic [63:0] in_name_w1 = '0;
  logic [63:0] in_name_w2 = '0;
  logic [47:0] in_name_w3 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_year;
  logic [63:0] out_name_w0;
  logic [63:0] out_name_w1;
  logic [63:0] out_name_w2;
  logic [47:0] out_name_w3;
  logic [6:0]  out_entry_count;

  rec_t        shadow_rows [TABLE_DEPTH];
  int unsigned shadow_count = 0;
  outcome_t    outcome_q [$];
  int unsigned bad_outcomes = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  int unsigned rx_hold_request = 0;

  sorted_record_table u_top (.*);

  always #5 clk = ~clk;

  function automatic logic [239:0] terminate_name(input logic [239:0] raw);
    bit ended;
    ended = 1'b0;
    for (int b = 0; b < NAME_SPAN; b++) begin
      if (raw[239 - 8 * b -: 8] == 8'h00 || b >= NAME_BYTES)
        ended = 1'b1;
      if (ended)
        raw[239 - 8 * b -: 8] = 8'h00;
    end
    return raw;
  endfunction

  function automatic outcome_t table_op_outcome(input logic [1:0] op, input logic [15:0] yr,
                                                input logic [6:0] rk, input logic [239:0] nm);
    outcome_t o;
    rec_t     fresh;
    int       pos;
    o = '0;
    o.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= TABLE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          fresh = {yr, terminate_name(nm)};
          pos = 0;
          while (pos < shadow_count && !(fresh < shadow_rows[pos]))
            pos++;
          for (int i = shadow_count; i > pos; i--)
            shadow_rows[i] = shadow_rows[i - 1];
          shadow_rows[pos] = fresh;
          shadow_count++;
        end
      end
      OP_DELETE, OP_READ: begin
        if (rk == 0 || rk > shadow_count) begin
          o.status = ST_RANGE;
        end else if (op == OP_READ) begin
          o.year = shadow_rows[rk - 1].year;
          o.w0   = shadow_rows[rk - 1].w0;
          o.w1   = shadow_rows[rk - 1].w1;
          o.w2   = shadow_rows[rk - 1].w2;
          o.w3   = shadow_rows[rk - 1].w3;
        end else begin
          for (int i = rk - 1; i + 1 < shadow_count; i++)
            shadow_rows[i] = shadow_rows[i + 1];
          shadow_count--;
        end
      end
      default: o.status = ST_RANGE;
    endcase
    o.count = 7'(shadow_count);
    return o;
  endfunction

  function automatic logic [239:0] text_name(input string s);
    logic [239:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < NAME_SPAN; i++)
      v[239 - 8 * i -: 8] = s[i];
    return v;
  endfunction

  function automatic logic [239:0] random_name();
    logic [239:0] v;
    int           len;
    int           style;
    v = 240'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom});
    style = $urandom_range(0, 9);
    if (style < 2)
      return v;
    len = (style < 8) ? $urandom_range(0, 6) : $urandom_range(0, 30);
    for (int b = 0; b < NAME_SPAN; b++) begin
      if (b < len)
        v[239 - 8 * b -: 8] = (style < 6) ? 8'("a" + $urandom_range(0, 2))
                                          : 8'($urandom_range(1, 255));
      else if (b == len || style[0])
        v[239 - 8 * b -: 8] = 8'h00;
    end
    return v;
  endfunction

  function automatic logic [15:0] random_year();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3, 4, 5, 6: return 16'(2000 + $urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] pick_rank();
    if (shadow_count != 0 && $urandom_range(0, 99) < 85)
      return 7'($urandom_range(1, shadow_count));
    case ($urandom_range(0, 2))
      0: return 7'd0;
      1: return 7'(shadow_count + 1);
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [15:0] yr,
                              input logic [6:0] rk, input logic [239:0] nm);
    int unsigned gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid    <= 1'b0;
      in_opcode   <= 2'($urandom);
      in_key_year <= 16'($urandom);
      in_rank     <= 7'($urandom);
      in_name_w0  <= {$urandom, $urandom};
      in_name_w3  <= 48'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_key_year <= yr;
    in_rank     <= rk;
    in_name_w0  <= nm[239:176];
    in_name_w1  <= nm[175:112];
    in_name_w2  <= nm[111:48];
    in_name_w3  <= nm[47:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    outcome_q.push_back(table_op_outcome(op, yr, rk, nm));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic compare_outcome();
    outcome_t want;
    outcome_t got;
    got.status = out_status;
    got.year   = out_year;
    got.w0     = out_name_w0;
    got.w1     = out_name_w1;
    got.w2     = out_name_w2;
    got.w3     = out_name_w3;
    got.count  = out_entry_count;
    if (outcome_q.size() == 0) begin
      bad_outcomes++;
      if (bad_outcomes <= 10)
        $display("%0t: result with none pending: status %0d count %0d",
                 $realtime, got.status, got.count);
      return;
    end
    want = outcome_q.pop_front();
    if (want.status !== got.status || want.year !== got.year || want.w0 !== got.w0 ||
        want.w1 !== got.w1 || want.w2 !== got.w2 || want.w3 !== got.w3 ||
        want.count !== got.count) begin
      bad_outcomes++;
      if (bad_outcomes <= 10) begin
        $display("%0t: expected st %0d yr %h name %h %h %h %h cnt %0d", $realtime,
                 want.status, want.year, want.w0, want.w1, want.w2, want.w3, want.count);
        $display("%0t: actual   st %0d yr %h name %h %h %h %h cnt %0d", $realtime,
                 got.status, got.year, got.w0, got.w1, got.w2, got.w3, got.count);
      end
    end
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned gap_left;
    hold_left = 0;
    gap_left = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (out_valid && out_ready)
        compare_outcome();
      if (rx_hold_request != 0) begin
        hold_left = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (gap_left != 0) begin
        out_ready <= 1'b0;
        gap_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_idle_en)
          gap_left = pick_gap();
      end
      @(posedge clk);
    end
  end

  task automatic test_empty_table();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_request(OP_READ, random_year(), 7'd1, random_name());
    send_request(OP_DELETE, random_year(), 7'd1, random_name());
    send_request(OP_READ, random_year(), 7'd0, random_name());
    send_request(OP_UNUSED, 16'hFFFF, 7'd127, '1);
    send_request(OP_DELETE, 16'h0000, 7'd127, '0);
    wait_drained();
  endtask

  task automatic test_key_order();
    logic [239:0] nm;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_request(OP_INSERT, 16'hFFFF, 7'd127, '1);
    send_request(OP_INSERT, 16'h0000, 7'd0, '0);
    send_request(OP_INSERT, 16'd2000, 7'd1, text_name("bob"));
    send_request(OP_INSERT, 16'd2000, 7'd1, text_name("alice"));
    nm = text_name("bob");
    nm[207:0] = 208'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    send_request(OP_INSERT, 16'd2000, 7'd1, nm);
    nm = text_name("alxce");
    nm[223:216] = 8'h00;
    send_request(OP_INSERT, 16'd2000, 7'd1, nm);
    send_request(OP_INSERT, 16'hFFFF, 7'd1, text_name("zzzzzzzzzzzzzzzzzzzzzzzzzzzzzz"));
    send_request(OP_INSERT, 16'd1999, 7'd1, '1);
    for (int r = 1; r <= 9; r++)
      send_request(OP_READ, random_year(), 7'(r), random_name());
    send_request(OP_DELETE, random_year(), 7'd8, random_name());
    send_request(OP_DELETE, random_year(), 7'd1, random_name());
    send_request(OP_DELETE, random_year(), 7'd3, random_name());
    send_request(OP_READ, random_year(), 7'd0, random_name());
    for (int r = 1; r <= 3; r++)
      send_request(OP_READ, random_year(), 7'(r), random_name());
    wait_drained();
  endtask

  task automatic test_full_table();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b0;
    while (shadow_count != 0)
      send_request(OP_DELETE, random_year(), 7'd1, random_name());
    while (shadow_count < TABLE_DEPTH)
      send_request(OP_INSERT, random_year(), 7'($urandom_range(0, 127)), random_name());
    send_request(OP_INSERT, random_year(), 7'd0, random_name());
    send_request(OP_INSERT, 16'h0000, 7'd0, '0);
    send_request(OP_READ, random_year(), 7'd64, random_name());
    send_request(OP_READ, random_year(), 7'd65, random_name());
    send_request(OP_READ, random_year(), 7'd127, random_name());
    send_request(OP_DELETE, random_year(), 7'd64, random_name());
    send_request(OP_INSERT, random_year(), 7'd64, random_name());
    repeat (4)
      send_request(OP_DELETE, random_year(), pick_rank(), random_name());
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold_request = 80;
    repeat (16)
      send_request(2'($urandom_range(0, 2)), random_year(), pick_rank(), random_name());
    wait_drained();
  endtask

  task automatic test_random_mix();
    logic [1:0]  op;
    int unsigned r;
    int unsigned ins_weight;
    for (int p = 0; p < 7; p++) begin
      tx_idle_en = (p & 1) != 0;
      rx_idle_en = (p & 2) != 0;
      ins_weight = (p % 3 != 2) ? 70 : 25;
      repeat (200) begin
        r = $urandom_range(0, 99);
        if (r < 2)
          op = OP_UNUSED;
        else if (r < 2 + ins_weight)
          op = OP_INSERT;
        else if (r[0])
          op = OP_DELETE;
        else
          op = OP_READ;
        send_request(op, random_year(),
                     (op == OP_INSERT) ? 7'($urandom_range(0, 127)) : pick_rank(),
                     random_name());
      end
      if (p == 3)
        wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_key_order();
    test_full_table();
    test_backpressure();
    test_random_mix();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_outcomes == 0 && outcome_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
